FILE: rtl/gfyu_pkg.sv
`default_nettype none

package gfyu_pkg;

    // block layout and value widths
    localparam int FRAME_BYTES = 22;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int YAW_WIDTH   = 48;

    // fixed packet bytes
    localparam logic [7:0] HDR_SYNC  = 8'h55;
    localparam logic [7:0] HDR_RATE  = 8'h52;
    localparam logic [7:0] HDR_ANGLE = 8'h53;

    // input operation codes
    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_IDLE = 2'd1,
        OP_ZERO = 2'd2
    } t_op;

    // status of the block collected by the byte parser
    typedef struct packed {
        logic        ready;
        logic        rate_ok;
        logic        angle_ok;
        logic [15:0] rate_raw;
        logic [15:0] angle_raw;
    } t_blk;

    // one result transaction
    typedef struct packed {
        logic                        rate_updated;
        logic                        angle_updated;
        logic signed [15:0]          yaw_rate;
        logic signed [YAW_WIDTH-1:0] yaw_total;
        logic signed [15:0]          turn_count;
    } t_res;

endpackage

`default_nettype wire

FILE: rtl/gfyu_in_if.sv
`default_nettype none

interface gfyu_in_if import gfyu_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink (input valid, input op, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/gfyu_out_if.sv
`default_nettype none

interface gfyu_out_if import gfyu_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic                        rate_updated;
    logic                        angle_updated;
    logic signed [15:0]          yaw_rate;
    logic signed [YAW_WIDTH-1:0] yaw_total;
    logic signed [15:0]          turn_count;

    modport source (output valid, output rate_updated, output angle_updated,
                    output yaw_rate, output yaw_total, output turn_count, input ready);
    modport sink (input valid, input rate_updated, input angle_updated,
                  input yaw_rate, input yaw_total, input turn_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/gyro_frame_yaw_unwrap.sv
`default_nettype none

// path: a line-idle transaction waits in the input register, and its result is then loaded
//   into the output register, where the sink takes it
// throughput: one transaction per cycle; input stalls only while a result waits
//   in the output register and the sink holds ready low
// reset: synchronous active-low; clears the parser, turn counter, offset and yaw
module gyro_frame_yaw_unwrap import gfyu_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gfyu_in_if.sink    i_in,
    gfyu_out_if.source o_out
);

    logic       r_in_valid;
    logic [1:0] r_op;
    logic [7:0] r_byte;
    logic       r_out_valid;
    t_res       r_out_res;

    t_blk blk;
    t_res res;
    logic produce;
    logic out_free;
    logic fire;
    logic out_load;

    // handshake between input register, work and output register
    assign out_free   = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && (!produce || out_free);
    assign out_load   = fire && produce;
    assign i_in.ready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_op   <= i_in.op;
            r_byte <= i_in.rx_byte;
        end
    end

    // byte parser
    gfyu_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (fire),
        .i_op    (r_op),
        .i_byte  (r_byte),
        .o_blk   (blk)
    );

    // angle unwrap and result assembly
    gfyu_unwrap u_unwrap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (fire),
        .i_op      (r_op),
        .i_blk     (blk),
        .o_produce (produce),
        .o_res     (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_res <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.rate_updated  = r_out_res.rate_updated;
    assign o_out.angle_updated = r_out_res.angle_updated;
    assign o_out.yaw_rate      = r_out_res.yaw_rate;
    assign o_out.yaw_total     = r_out_res.yaw_total;
    assign o_out.turn_count    = r_out_res.turn_count;

    // results come only from idle transactions
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_op == OP_IDLE))
        else $error("result from non-idle transaction");

    // a loaded result is presented next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("loaded result not valid");

    // a stalled item keeps its place in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> r_in_valid && $stable(r_op) && $stable(r_byte))
        else $error("stalled input lost");

endmodule

`default_nettype wire

FILE: rtl/gfyu_parse.sv
`default_nettype none

module gfyu_parse import gfyu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_byte,
    output t_blk            o_blk
);

    // byte positions inside the block
    localparam logic [POS_W-1:0] P_R_SYNC  = POS_W'(0);
    localparam logic [POS_W-1:0] P_R_ID    = POS_W'(1);
    localparam logic [POS_W-1:0] P_R_Z0    = POS_W'(2);
    localparam logic [POS_W-1:0] P_R_Z1    = POS_W'(3);
    localparam logic [POS_W-1:0] P_R_D0    = POS_W'(4);
    localparam logic [POS_W-1:0] P_R_D1    = POS_W'(5);
    localparam logic [POS_W-1:0] P_R_LO    = POS_W'(6);
    localparam logic [POS_W-1:0] P_R_HI    = POS_W'(7);
    localparam logic [POS_W-1:0] P_R_Z2    = POS_W'(8);
    localparam logic [POS_W-1:0] P_R_Z3    = POS_W'(9);
    localparam logic [POS_W-1:0] P_R_SUM   = POS_W'(10);
    localparam logic [POS_W-1:0] P_A_SYNC  = POS_W'(11);
    localparam logic [POS_W-1:0] P_A_ID    = POS_W'(12);
    localparam logic [POS_W-1:0] P_A_Z0    = POS_W'(13);
    localparam logic [POS_W-1:0] P_A_Z1    = POS_W'(14);
    localparam logic [POS_W-1:0] P_A_Z2    = POS_W'(15);
    localparam logic [POS_W-1:0] P_A_Z3    = POS_W'(16);
    localparam logic [POS_W-1:0] P_A_LO    = POS_W'(17);
    localparam logic [POS_W-1:0] P_A_HI    = POS_W'(18);
    localparam logic [POS_W-1:0] P_A_D0    = POS_W'(19);
    localparam logic [POS_W-1:0] P_A_D1    = POS_W'(20);
    localparam logic [POS_W-1:0] P_A_SUM   = POS_W'(21);
    localparam logic [POS_W-1:0] P_LAST    = POS_W'(FRAME_BYTES - 1);

    logic [POS_W-1:0] r_pos;
    logic             r_seen;
    logic [7:0]       r_rate_sum;
    logic [7:0]       r_angle_sum;
    logic             r_rate_hdr;
    logic             r_angle_hdr;
    logic [15:0]      r_rate_raw;
    logic [15:0]      r_angle_raw;
    logic             r_rate_ok;
    logic             r_angle_ok;

    logic is_byte;
    logic is_idle;

    assign is_byte = (i_op == OP_BYTE);
    assign is_idle = (i_op == OP_IDLE);

    // block status toward the unwrap stage
    assign o_blk.ready     = (r_pos == '0) && r_seen;
    assign o_blk.rate_ok   = r_rate_ok;
    assign o_blk.angle_ok  = r_angle_ok;
    assign o_blk.rate_raw  = r_rate_raw;
    assign o_blk.angle_raw = r_angle_raw;

    // byte position, checksums and header checks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_seen      <= 1'b0;
            r_rate_sum  <= '0;
            r_angle_sum <= '0;
            r_rate_hdr  <= 1'b0;
            r_angle_hdr <= 1'b0;
            r_rate_raw  <= '0;
            r_angle_raw <= '0;
            r_rate_ok   <= 1'b0;
            r_angle_ok  <= 1'b0;
        end else if (i_step && is_byte) begin
            case (r_pos)
                P_R_SYNC: begin
                    r_rate_hdr <= (i_byte == HDR_SYNC);
                    r_rate_sum <= i_byte;
                end
                P_R_ID: begin
                    r_rate_hdr <= r_rate_hdr && (i_byte == HDR_RATE);
                    r_rate_sum <= r_rate_sum + i_byte;
                end
                P_R_Z0, P_R_Z1, P_R_Z2, P_R_Z3: begin
                    r_rate_hdr <= r_rate_hdr && (i_byte == 8'h00);
                end
                P_R_D0, P_R_D1: begin
                    r_rate_sum <= r_rate_sum + i_byte;
                end
                P_R_LO: begin
                    r_rate_sum      <= r_rate_sum + i_byte;
                    r_rate_raw[7:0] <= i_byte;
                end
                P_R_HI: begin
                    r_rate_sum       <= r_rate_sum + i_byte;
                    r_rate_raw[15:8] <= i_byte;
                end
                P_R_SUM: begin
                    r_rate_ok <= r_rate_hdr && (i_byte == r_rate_sum);
                end
                P_A_SYNC: begin
                    r_angle_hdr <= (i_byte == HDR_SYNC);
                    r_angle_sum <= i_byte;
                end
                P_A_ID: begin
                    r_angle_hdr <= r_angle_hdr && (i_byte == HDR_ANGLE);
                    r_angle_sum <= r_angle_sum + i_byte;
                end
                P_A_Z0, P_A_Z1, P_A_Z2, P_A_Z3: begin
                    r_angle_hdr <= r_angle_hdr && (i_byte == 8'h00);
                end
                P_A_LO: begin
                    r_angle_sum      <= r_angle_sum + i_byte;
                    r_angle_raw[7:0] <= i_byte;
                end
                P_A_HI: begin
                    r_angle_sum       <= r_angle_sum + i_byte;
                    r_angle_raw[15:8] <= i_byte;
                end
                P_A_D0, P_A_D1: begin
                    r_angle_sum <= r_angle_sum + i_byte;
                end
                P_A_SUM: begin
                    r_angle_ok <= r_angle_hdr && (i_byte == r_angle_sum);
                end
                default: begin
                end
            endcase
            // wrap at end of block
            if (r_pos >= P_LAST) begin
                r_pos  <= '0;
                r_seen <= 1'b1;
            end else begin
                r_pos <= r_pos + POS_W'(1);
            end
        end else if (i_step && is_idle) begin
            r_pos  <= '0;
            r_seen <= 1'b0;
        end
    end

    // position never leaves the block
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= P_LAST)
        else $error("byte position out of range");

    // idle always restarts the block
    a_idle_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && is_idle) |=> (r_pos == '0) && !r_seen)
        else $error("idle did not restart block");

    // a finished block is seen right after its last byte
    a_block_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && is_byte && r_pos == P_LAST) |=> o_blk.ready)
        else $error("block end not flagged");

endmodule

`default_nettype wire

FILE: rtl/gfyu_unwrap.sv
`default_nettype none

module gfyu_unwrap import gfyu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [1:0] i_op,
    input  wire t_blk       i_blk,
    output logic            o_produce,
    output t_res            o_res
);

    logic [15:0]          r_prev_angle;
    logic [15:0]          r_revs;
    logic [YAW_WIDTH-1:0] r_zero_off;
    logic [YAW_WIDTH-1:0] r_cur_yaw;
    logic [15:0]          r_cur_rate;

    logic signed [16:0]   diff;
    logic                 step_up;
    logic                 step_down;
    logic [15:0]          n_revs;
    logic [YAW_WIDTH-1:0] n_yaw;
    logic                 is_zero;

    assign o_produce = (i_op == OP_IDLE) && i_blk.ready;
    assign is_zero   = (i_op == OP_ZERO);

    // jump between successive angles, more than half a turn steps the counter
    assign diff      = $signed({r_prev_angle[15], r_prev_angle})
                     - $signed({i_blk.angle_raw[15], i_blk.angle_raw});
    assign step_up   = diff > 17'sd32768;
    assign step_down = diff < -17'sd32768;

    // saturating revolution counter
    always_comb begin
        n_revs = r_revs;
        if (step_up && r_revs != 16'h7fff) begin
            n_revs = r_revs + 16'd1;
        end else if (step_down && r_revs != 16'h8000) begin
            n_revs = r_revs - 16'd1;
        end
    end

    // turns times 65536 plus angle, less the zero offset
    assign n_yaw = {{(YAW_WIDTH-32){n_revs[15]}}, n_revs, 16'h0000}
                 + {{(YAW_WIDTH-16){i_blk.angle_raw[15]}}, i_blk.angle_raw}
                 - r_zero_off;

    // result of this idle transaction
    assign o_res.rate_updated  = i_blk.rate_ok;
    assign o_res.angle_updated = i_blk.angle_ok;
    assign o_res.yaw_rate      = i_blk.rate_ok ? i_blk.rate_raw : r_cur_rate;
    assign o_res.yaw_total     = i_blk.angle_ok ? n_yaw : r_cur_yaw;
    assign o_res.turn_count    = i_blk.angle_ok ? n_revs : r_revs;

    // tracked yaw state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_angle <= '0;
            r_revs       <= '0;
            r_zero_off   <= '0;
            r_cur_yaw    <= '0;
            r_cur_rate   <= '0;
        end else if (i_step) begin
            if (o_produce) begin
                if (i_blk.rate_ok) begin
                    r_cur_rate <= i_blk.rate_raw;
                end
                if (i_blk.angle_ok) begin
                    r_prev_angle <= i_blk.angle_raw;
                    r_revs       <= n_revs;
                    r_cur_yaw    <= n_yaw;
                end
            end else if (is_zero) begin
                r_zero_off <= r_zero_off + r_cur_yaw;
            end
        end
    end

    // counter moves only on an accepted angle
    a_revs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_step && o_produce && i_blk.angle_ok) |=> $stable(r_revs))
        else $error("turn counter moved without angle update");

    // counter moves by at most one per angle
    a_revs_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_produce && i_blk.angle_ok) |=>
            (r_revs == $past(r_revs)) || (r_revs == $past(r_revs) + 16'd1)
            || (r_revs == $past(r_revs) - 16'd1))
        else $error("turn counter jumped");

    // zero capture leaves the yaw value alone
    a_zero_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && is_zero) |=> $stable(r_cur_yaw))
        else $error("zero capture changed yaw");

endmodule

`default_nettype wire

FILE: test/gyro_frame_yaw_unwrap_tb.sv
`timescale 1ns / 100ps

module gyro_frame_yaw_unwrap_tb import gfyu_pkg::*; ();

    // op code that the block must ignore
    localparam logic [1:0] OP_SPARE = 2'd3;

    // expected yaw frame results, kept by a bit-true copy of the parser and unwrapper
    class frame_result_board;
        // parser state
        logic [4:0]           byte_pos     = '0;
        logic                 block_seen   = 1'b0;
        logic [7:0]           rate_sum     = '0;
        logic [7:0]           angle_sum    = '0;
        logic                 rate_hdr_ok  = 1'b0;
        logic                 angle_hdr_ok = 1'b0;
        logic [15:0]          rate_raw     = '0;
        logic [15:0]          angle_raw    = '0;
        logic                 rate_ok      = 1'b0;
        logic                 angle_ok     = 1'b0;
        // unwrap state
        logic [15:0]          last_angle   = '0;
        logic [15:0]          turns        = '0;
        logic [YAW_WIDTH-1:0] offset       = '0;
        logic [YAW_WIDTH-1:0] yaw_now      = '0;
        logic [15:0]          rate_now     = '0;

        t_res expected_frames[$];
        int   errors = 0;

        task report(string what);
            $display("%0t mismatch: %s", $realtime, what);
            errors++;
        endtask

        // one received byte into the 22-byte block
        function void parse_byte(logic [7:0] b);
            case (byte_pos)
                5'd0: begin
                    rate_hdr_ok = (b == HDR_SYNC);
                    rate_sum    = b;
                end
                5'd1: begin
                    rate_hdr_ok = rate_hdr_ok && (b == HDR_RATE);
                    rate_sum    = rate_sum + b;
                end
                5'd2, 5'd3, 5'd8, 5'd9: rate_hdr_ok = rate_hdr_ok && (b == 8'h00);
                5'd4, 5'd5: rate_sum = rate_sum + b;
                5'd6: begin
                    rate_sum      = rate_sum + b;
                    rate_raw[7:0] = b;
                end
                5'd7: begin
                    rate_sum       = rate_sum + b;
                    rate_raw[15:8] = b;
                end
                5'd10: rate_ok = rate_hdr_ok && (b == rate_sum);
                5'd11: begin
                    angle_hdr_ok = (b == HDR_SYNC);
                    angle_sum    = b;
                end
                5'd12: begin
                    angle_hdr_ok = angle_hdr_ok && (b == HDR_ANGLE);
                    angle_sum    = angle_sum + b;
                end
                5'd13, 5'd14, 5'd15, 5'd16: angle_hdr_ok = angle_hdr_ok && (b == 8'h00);
                5'd17: begin
                    angle_sum      = angle_sum + b;
                    angle_raw[7:0] = b;
                end
                5'd18: begin
                    angle_sum       = angle_sum + b;
                    angle_raw[15:8] = b;
                end
                5'd19, 5'd20: angle_sum = angle_sum + b;
                5'd21: angle_ok = angle_hdr_ok && (b == angle_sum);
                default: ;
            endcase
            if (byte_pos >= FRAME_BYTES - 1) begin
                byte_pos   = '0;
                block_seen = 1'b1;
            end else begin
                byte_pos = byte_pos + 5'd1;
            end
        endfunction

        // turn counter steps on a jump of more than half a turn, saturating
        function void unwrap_angle();
            int prev_i, cur_i, diff, turns_i;
            prev_i  = $signed(last_angle);
            cur_i   = $signed(angle_raw);
            turns_i = $signed(turns);
            diff    = prev_i - cur_i;
            if (diff > 32768) begin
                if (turns_i < 32767) turns_i++;
            end else if (diff < -32768) begin
                if (turns_i > -32768) turns_i--;
            end
            turns      = turns_i[15:0];
            last_angle = angle_raw;
            yaw_now    = ({{(YAW_WIDTH-16){turns[15]}}, turns} << 16)
                       + {{(YAW_WIDTH-16){angle_raw[15]}}, angle_raw} - offset;
        endfunction

        // accepted input transaction
        function void take_item(logic [1:0] op, logic [7:0] b);
            t_res want;
            case (op)
                OP_BYTE: parse_byte(b);
                OP_IDLE: begin
                    if (byte_pos == '0 && block_seen) begin
                        if (rate_ok) rate_now = rate_raw;
                        if (angle_ok) unwrap_angle();
                        want.rate_updated  = rate_ok;
                        want.angle_updated = angle_ok;
                        want.yaw_rate      = rate_now;
                        want.yaw_total     = yaw_now;
                        want.turn_count    = turns;
                        expected_frames.push_back(want);
                    end
                    byte_pos   = '0;
                    block_seen = 1'b0;
                end
                OP_ZERO: offset = offset + yaw_now;
                default: ;
            endcase
        endfunction

        // accepted result transaction against the oldest expectation
        task check_result(t_res got);
            t_res want;
            if (expected_frames.size() == 0) begin
                report("result transaction with nothing expected");
                return;
            end
            want = expected_frames.pop_front();
            if (got.rate_updated !== want.rate_updated)
                report($sformatf("rate_updated got %0b expected %0b",
                                 got.rate_updated, want.rate_updated));
            if (got.angle_updated !== want.angle_updated)
                report($sformatf("angle_updated got %0b expected %0b",
                                 got.angle_updated, want.angle_updated));
            if (got.yaw_rate !== want.yaw_rate)
                report($sformatf("yaw_rate got %0d expected %0d", got.yaw_rate, want.yaw_rate));
            if (got.yaw_total !== want.yaw_total)
                report($sformatf("yaw_total got %0d expected %0d",
                                 got.yaw_total, want.yaw_total));
            if (got.turn_count !== want.turn_count)
                report($sformatf("turn_count got %0d expected %0d",
                                 got.turn_count, want.turn_count));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   send_gap_pct = 0;
    int   stall_pct    = 0;
    int   hold_request = 0;

    frame_result_board board = new();

    gfyu_in_if  in_if ();
    gfyu_out_if out_if ();

    gyro_frame_yaw_unwrap DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("FAIL gyro_frame_yaw_unwrap");
        $finish;
    end

    // receiver: random stalls plus a long hold when asked
    initial begin
        int hold_left;
        hold_left    = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        t_res got;
        if (rst_n && out_if.valid && out_if.ready) begin
            got.rate_updated  = out_if.rate_updated;
            got.angle_updated = out_if.angle_updated;
            got.yaw_rate      = out_if.yaw_rate;
            got.yaw_total     = out_if.yaw_total;
            got.turn_count    = out_if.turn_count;
            board.check_result(got);
        end
    end

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(logic [1:0] op, logic [7:0] data);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.op      <= op;
        in_if.rx_byte <= data;
        do @(posedge clk); while (!in_if.ready);
        board.take_item(op, data);
    endtask

    // one 22-byte block; bad_pos >= 0 flips bits of that byte
    task automatic send_block(logic [15:0] rate, logic [15:0] angle, int bad_pos);
        logic [7:0] blk [FRAME_BYTES];
        blk[0]  = HDR_SYNC;
        blk[1]  = HDR_RATE;
        blk[2]  = 8'h00;
        blk[3]  = 8'h00;
        blk[4]  = 8'($urandom);
        blk[5]  = 8'($urandom);
        blk[6]  = rate[7:0];
        blk[7]  = rate[15:8];
        blk[8]  = 8'h00;
        blk[9]  = 8'h00;
        blk[10] = blk[0] + blk[1] + blk[4] + blk[5] + blk[6] + blk[7];
        blk[11] = HDR_SYNC;
        blk[12] = HDR_ANGLE;
        blk[13] = 8'h00;
        blk[14] = 8'h00;
        blk[15] = 8'h00;
        blk[16] = 8'h00;
        blk[17] = angle[7:0];
        blk[18] = angle[15:8];
        blk[19] = 8'($urandom);
        blk[20] = 8'($urandom);
        blk[21] = blk[11] + blk[12] + blk[17] + blk[18] + blk[19] + blk[20];
        if (bad_pos >= 0) blk[bad_pos] = blk[bad_pos] ^ 8'($urandom_range(255, 1));
        foreach (blk[k]) send_item(OP_BYTE, blk[k]);
    endtask

    task automatic send_idle();
        send_item(OP_IDLE, 8'($urandom));
    endtask

    // raw values, leaning on the extremes and the half-turn boundary
    function automatic logic [15:0] pick_value();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // one random stretch of traffic, mostly well-formed frames
    task automatic random_unit();
        int pick, n;
        pick = $urandom_range(99);
        if (pick < 58) begin
            send_block(pick_value(), pick_value(), -1);
            send_idle();
        end else if (pick < 68) begin
            // one damaged byte in an otherwise good block
            send_block(pick_value(), pick_value(), $urandom_range(FRAME_BYTES - 1));
            send_idle();
        end else if (pick < 75) begin
            // two blocks in one frame, only the last counts
            send_block(pick_value(), pick_value(), ($urandom_range(2) == 0) ? 10 : -1);
            send_block(pick_value(), pick_value(), -1);
            send_idle();
        end else if (pick < 83) begin
            // frame length not a multiple of the block
            n = $urandom_range(FRAME_BYTES - 1, 1);
            if ($urandom_range(1)) send_block(pick_value(), pick_value(), -1);
            repeat (n) send_item(OP_BYTE, 8'($urandom));
            send_idle();
        end else if (pick < 91) begin
            repeat ($urandom_range(2, 1)) send_item(OP_ZERO, 8'($urandom));
        end else if (pick < 95) begin
            send_idle();
            send_idle();
        end else begin
            // ignored op code and stray bytes
            send_item(OP_SPARE, 8'($urandom));
            repeat ($urandom_range(4)) send_item(OP_BYTE, 8'($urandom));
            send_item(OP_SPARE, 8'($urandom));
            send_idle();
        end
    endtask

    // stimulus and end of run
    initial begin
        in_if.valid   = 1'b0;
        in_if.op      = OP_BYTE;
        in_if.rx_byte = 8'h00;
        rst_n         = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty idle, ignored op, zero at reset, extremes, wraps, bad packet
        send_idle();
        send_item(OP_SPARE, 8'hFF);
        send_item(OP_ZERO, 8'hAA);
        send_block(16'h8000, 16'h7FFF, -1);
        send_idle();
        send_block(16'h7FFF, 16'hFFFE, -1);
        send_idle();
        send_item(OP_ZERO, 8'h55);
        send_item(OP_ZERO, 8'h00);
        send_block(16'h1234, 16'h7FFF, 10);
        send_idle();
        repeat (5) send_item(OP_BYTE, 8'hFF);
        send_idle();

        // random phases with different idle patterns
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 67; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 67; end
                default: begin send_gap_pct = 10; stall_pct = 10; end
            endcase
            repeat (8) random_unit();
        end

        // long receiver hold while frames keep coming
        send_gap_pct = 0;
        stall_pct    = 0;
        hold_request = 300;
        repeat (8) random_unit();

        @(negedge clk);
        in_if.valid <= 1'b0;
        while (board.expected_frames.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (board.errors == 0) begin
            $display("PASS gyro_frame_yaw_unwrap");
        end else begin
            $display("FAIL gyro_frame_yaw_unwrap");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/gfyu_pkg.sv
rtl/gfyu_in_if.sv
rtl/gfyu_out_if.sv
rtl/gfyu_parse.sv
rtl/gfyu_unwrap.sv
rtl/gyro_frame_yaw_unwrap.sv
test/gyro_frame_yaw_unwrap_tb.sv
